[rtl/core/afk_pkg.sv]
package afk_pkg;

  // Number of entries in the arctangent table
  localparam int TableLen = 24;

  // CORDIC start value: gain K in Q30
  localparam logic signed [32:0] GainQ30 = 33'sd652032874;

  // Width of a CORDIC datapath word (Q30 with headroom)
  localparam int CordicW = 33;

  // Q15 sample width, link length width, field widths
  localparam int Q15W = 16;
  localparam int LenW = 16;
  localparam int InW = 16;
  localparam int OutW = 19;

  // Radius and height accumulators: four 33-bit products
  localparam int AccW = 35;

  // Output saturation limits
  localparam logic signed [OutW-1:0] OutMax = 19'sd262143;
  localparam logic signed [OutW-1:0] OutMin = -19'sd262144;

  // Register indexes on the configuration port
  localparam logic [7:0] RegLink1 = 8'd0;
  localparam logic [7:0] RegLink2 = 8'd1;
  localparam logic [7:0] RegLink3 = 8'd2;
  localparam logic [7:0] RegLink4 = 8'd3;

  // Link length reset values
  localparam logic [LenW-1:0] Link1Rst = 16'd26874;
  localparam logic [LenW-1:0] Link2Rst = 16'd7869;
  localparam logic [LenW-1:0] Link3Rst = 16'd7936;
  localparam logic [LenW-1:0] Link4Rst = 16'd13320;

  // atan(2^-i) as a 32-bit binary angle (2^32 = one turn)
  localparam logic [31:0] AtanTurn [TableLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

[rtl/core/afk_cordic_lane.sv]
// Pipelined rotation-mode CORDIC: one binary angle in, cos and sin in Q15 out.
// One stage per register, between the input register and the output register.
module afk_cordic_lane #(
  parameter int ANGLE_BITS = 16,
  parameter int STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [ANGLE_BITS-1:0]               angle_i,
  output logic signed [afk_pkg::Q15W-1:0]     cos_o,
  output logic signed [afk_pkg::Q15W-1:0]     sin_o
);

  localparam int N = (STAGES < afk_pkg::TableLen) ? STAGES : afk_pkg::TableLen;
  localparam int W = afk_pkg::CordicW;
  localparam logic [31:0] Half = 32'd1 << (31 - ANGLE_BITS);

  logic signed [W-1:0]    x_q [N+1];
  logic signed [W-1:0]    y_q [N+1];
  logic [ANGLE_BITS-1:0]  z_q [N+1];
  logic                   flip_q [N+1];

  logic                   flip_in;
  logic signed [W-1:0]    x_fin, y_fin, x_rnd, y_rnd;
  logic signed [afk_pkg::Q15W-1:0] cos_d, sin_d;

  // Saturate to Q15
  function automatic logic signed [afk_pkg::Q15W-1:0] sat_q15(input logic signed [W-1:0] v);
    if (v > $signed(W'(32767))) begin
      sat_q15 = 16'sd32767;
    end else if (v < -$signed(W'(32768))) begin
      sat_q15 = -16'sd32768;
    end else begin
      sat_q15 = v[afk_pkg::Q15W-1:0];
    end
  endfunction

  // Fold the angle into the right half plane
  assign flip_in = angle_i[ANGLE_BITS-1] ^ angle_i[ANGLE_BITS-2];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= afk_pkg::GainQ30;
      y_q[0]    <= '0;
      z_q[0]    <= flip_in ? {~angle_i[ANGLE_BITS-1], angle_i[ANGLE_BITS-2:0]} : angle_i;
      flip_q[0] <= flip_in;
    end
  end

  // Micro-rotation stages
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [31:0] StepFull = afk_pkg::AtanTurn[k] + Half;
    localparam logic [ANGLE_BITS-1:0] Step = StepFull[31 -: ANGLE_BITS];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[k+1] <= flip_q[k];
        if (z_q[k][ANGLE_BITS-1]) begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + Step;
        end else begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - Step;
        end
      end
    end
  end

  // Undo the fold, round and saturate
  assign x_fin = flip_q[N] ? -x_q[N] : x_q[N];
  assign y_fin = flip_q[N] ? -y_q[N] : y_q[N];
  assign x_rnd = (x_fin + W'(16384)) >>> 15;
  assign y_rnd = (y_fin + W'(16384)) >>> 15;
  assign cos_d = sat_q15(x_rnd);
  assign sin_d = sat_q15(y_rnd);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= cos_d;
      sin_o <= sin_d;
    end
  end

endmodule

[rtl/core/afk_merge.sv]
// Merging stage: weights the four pitch lanes by link length, then turns
// the radius by the base yaw. Three register stages.
module afk_merge (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [afk_pkg::Q15W-1:0]     cos_i [4],
  input  logic signed [afk_pkg::Q15W-1:0]     sin_i [4],
  input  logic signed [afk_pkg::Q15W-1:0]     base_cos_i,
  input  logic signed [afk_pkg::Q15W-1:0]     base_sin_i,
  input  logic [afk_pkg::LenW-1:0]            len_i [4],
  output logic signed [afk_pkg::OutW-1:0]     x_pos_o,
  output logic signed [afk_pkg::OutW-1:0]     y_pos_o,
  output logic signed [afk_pkg::OutW-1:0]     z_pos_o
);

  localparam int AccW = afk_pkg::AccW;
  localparam int PW = AccW + afk_pkg::Q15W;
  localparam int OW = afk_pkg::OutW;

  logic signed [AccW-1:0] rho_d, hgt_d, rho_q, hgt_q;
  logic signed [afk_pkg::Q15W-1:0] bc_q, bs_q;
  logic signed [PW-1:0] px_q, py_q;
  logic signed [AccW-1:0] hgt2_q;
  logic signed [PW-1:0] px_r, py_r;
  logic signed [AccW-1:0] hz_r;

  function automatic logic signed [OW-1:0] sat_out(input logic signed [PW-1:0] v);
    if (v > PW'(afk_pkg::OutMax)) begin
      sat_out = afk_pkg::OutMax;
    end else if (v < PW'(afk_pkg::OutMin)) begin
      sat_out = afk_pkg::OutMin;
    end else begin
      sat_out = v[OW-1:0];
    end
  endfunction

  // Length-weighted sums
  always_comb begin
    rho_d = '0;
    hgt_d = '0;
    for (int k = 0; k < 4; k++) begin
      rho_d = rho_d + AccW'($signed({1'b0, len_i[k]}) * cos_i[k]);
      hgt_d = hgt_d + AccW'($signed({1'b0, len_i[k]}) * sin_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rho_q <= rho_d;
      hgt_q <= hgt_d;
      bc_q  <= base_cos_i;
      bs_q  <= base_sin_i;
    end
  end

  // Base yaw rotation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= PW'(rho_q) * PW'(bc_q);
      py_q   <= PW'(rho_q) * PW'(bs_q);
      hgt2_q <= hgt_q;
    end
  end

  // Round half up and saturate
  assign px_r = (px_q + (PW'(1) <<< 29)) >>> 30;
  assign py_r = (py_q + (PW'(1) <<< 29)) >>> 30;
  assign hz_r = (hgt2_q + AccW'(16384)) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_pos_o <= sat_out(px_r);
      y_pos_o <= sat_out(py_r);
      z_pos_o <= sat_out(PW'(hz_r));
    end
  end

endmodule

[rtl/core/arm_forward_kinematics_top.sv]
// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   base, shoulder, elbow, wrist, tool angles
// output    out_valid_o / out_stall_i x_pos_o, y_pos_o, z_pos_o
// config    cfg_we_i                  cfg_index_i, cfg_data_i
//
// One transaction per cycle unless the output stalls; the path runs through
// the CORDIC stages of the five lanes, then the three merge stages.
// The whole pipeline holds while the output register is full and stalled.
// Reset clears the valid line and loads the link length reset values.
module arm_forward_kinematics_top #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [afk_pkg::InW-1:0]      base_angle_i,
  input  logic signed [afk_pkg::InW-1:0]      shoulder_angle_i,
  input  logic signed [afk_pkg::InW-1:0]      elbow_angle_i,
  input  logic signed [afk_pkg::InW-1:0]      wrist_angle_i,
  input  logic signed [afk_pkg::InW-1:0]      tool_angle_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [afk_pkg::OutW-1:0]     x_pos_o,
  output logic signed [afk_pkg::OutW-1:0]     y_pos_o,
  output logic signed [afk_pkg::OutW-1:0]     z_pos_o,
  input  logic                                cfg_we_i,
  input  logic [7:0]                          cfg_index_i,
  input  logic [afk_pkg::LenW-1:0]            cfg_data_i
);

  localparam int N = (CORDIC_STAGES < afk_pkg::TableLen) ? CORDIC_STAGES
                                                          : afk_pkg::TableLen;
  localparam int Depth = N + 5;

  logic en;
  logic [Depth-1:0] vld_q, vld_d;
  logic [afk_pkg::LenW-1:0] len_q [4];
  logic [afk_pkg::InW-1:0] sum [4];
  logic [ANGLE_BITS-1:0] ang [5];
  logic [31:0] wide [5];
  logic signed [afk_pkg::Q15W-1:0] c [5];
  logic signed [afk_pkg::Q15W-1:0] s [5];

  // Pipeline moves unless the output register is held
  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Link length registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0] <= afk_pkg::Link1Rst;
      len_q[1] <= afk_pkg::Link2Rst;
      len_q[2] <= afk_pkg::Link3Rst;
      len_q[3] <= afk_pkg::Link4Rst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        afk_pkg::RegLink1: len_q[0] <= cfg_data_i;
        afk_pkg::RegLink2: len_q[1] <= cfg_data_i;
        afk_pkg::RegLink3: len_q[2] <= cfg_data_i;
        afk_pkg::RegLink4: len_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Cumulative pitch angles, wrapping
  assign sum[0] = shoulder_angle_i;
  assign sum[1] = sum[0] + elbow_angle_i;
  assign sum[2] = sum[1] + wrist_angle_i;
  assign sum[3] = sum[2] + tool_angle_i;

  assign wide[0] = {base_angle_i, 16'b0};
  for (genvar k = 0; k < 4; k++) begin : g_wide
    assign wide[k+1] = {sum[k], 16'b0};
  end

  // Five CORDIC lanes: lane 0 is the base yaw
  for (genvar k = 0; k < 5; k++) begin : g_lane
    assign ang[k] = wide[k][31 -: ANGLE_BITS];
    afk_cordic_lane #(
      .ANGLE_BITS(ANGLE_BITS),
      .STAGES(CORDIC_STAGES)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .angle_i(ang[k]),
      .cos_o  (c[k]),
      .sin_o  (s[k])
    );
  end

  afk_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (en),
    .cos_i     (c[1:4]),
    .sin_i     (s[1:4]),
    .base_cos_i(c[0]),
    .base_sin_i(s[0]),
    .len_i     (len_q),
    .x_pos_o   (x_pos_o),
    .y_pos_o   (y_pos_o),
    .z_pos_o   (z_pos_o)
  );

  // Valid line alongside the datapath
  assign vld_d = {vld_q[Depth-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o = vld_q[Depth-1];

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> vld_q[0])
    else $error("accepted transaction not in pipeline");

  a_out_from_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[Depth-2]))
    else $error("output valid without predecessor");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(x_pos_o) && $stable(z_pos_o))
    else $error("held result changed");
`endif

endmodule
